@@ rtl/prds_pkg.sv @@
// ----------------------------------------------------------------------------
// prds_pkg
// Shared types and constants for the point reprojection depth splat unit.
// ----------------------------------------------------------------------------
package prds_pkg;

    typedef enum logic [2:0] {
        REG_FOCAL_X      = 3'd0,
        REG_FOCAL_Y      = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5
    } reg_idx_t;

    localparam int unsigned PROD_W = 64;
    localparam int unsigned QSAT_W = 41;
    localparam int unsigned U_W    = 44;
    localparam int unsigned PIX_W  = 28;
    localparam int unsigned CNT_W  = 6;
    localparam logic [PROD_W-1:0] QUOT_SAT = 64'h0000_0100_0000_0000;

    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_step;
        logic mul;
        logic sel;
        logic div_step;
        logic div_store;
        logic proj;
        logic fin;
        logic mem_test;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic z_pos;
        logic div_last;
        logic clr_last;
        logic visible;
    } status_t;

endpackage

@@ rtl/prds_ram.sv @@
// ----------------------------------------------------------------------------
// prds_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module prds_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 262144
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/prds_ctrl.sv @@
// ----------------------------------------------------------------------------
// prds_ctrl
// Sequencer: clear sweep, two multiply/divide passes, depth test, output.
// ----------------------------------------------------------------------------
module prds_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  prds_pkg::status_t st,
    output prds_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_MUL, S_DIV, S_PROJ, S_FIN, S_READ, S_TEST, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.sel      = sel_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (st.kind) begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLEAR;
                end else if (!st.z_pos) begin
                    state_next = S_DONE;
                end else begin
                    sel_next   = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    cmd.div_store = 1'b1;
                    if (!sel_reg) begin
                        sel_next   = 1'b1;
                        state_next = S_MUL;
                    end else begin
                        state_next = S_PROJ;
                    end
                end
            end
            S_PROJ: begin
                cmd.proj   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                // ram read of the pixel address is in flight this cycle
                state_next = st.visible ? S_TEST : S_DONE;
            end
            S_TEST: begin
                cmd.mem_test = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ rtl/prds_dpath.sv @@
// ----------------------------------------------------------------------------
// prds_dpath
// Datapath: configuration, multiplier, radix-2 divider, rounding, depth store.
// ----------------------------------------------------------------------------
module prds_dpath #(
    parameter int unsigned MAX_FRAME_WIDTH  = 512,
    parameter int unsigned MAX_FRAME_HEIGHT = 512
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_kind,
    input  logic signed [31:0]  s_point_x,
    input  logic signed [31:0]  s_point_y,
    input  logic signed [31:0]  s_point_z,
    input  logic signed [15:0]  s_ref_u,
    input  logic signed [15:0]  s_ref_v,
    input  prds_pkg::cmd_t      cmd,
    output prds_pkg::status_t   st,
    output logic [8:0]          m_pixel_x,
    output logic [8:0]          m_pixel_y,
    output logic                m_visible,
    output logic                m_written,
    output logic [31:0]         m_abs_du,
    output logic [31:0]         m_abs_dv
);

    localparam int unsigned DEPTH  = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned XW     = $clog2(MAX_FRAME_WIDTH);
    localparam int unsigned YW     = $clog2(MAX_FRAME_HEIGHT);
    localparam int unsigned PW     = prds_pkg::PROD_W;
    localparam int unsigned QW     = prds_pkg::QSAT_W;
    localparam int unsigned UW     = prds_pkg::U_W;
    localparam int unsigned RW     = prds_pkg::PIX_W;
    localparam int unsigned CW     = prds_pkg::CNT_W;

    // configuration
    logic [31:0] focal_x_reg, focal_y_reg;
    logic [24:0] center_x_reg, center_y_reg;
    logic [9:0]  frame_w_reg, frame_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= 32'd65536;
            focal_y_reg  <= 32'd65536;
            center_x_reg <= 25'd16777216;
            center_y_reg <= 25'd16777216;
            frame_w_reg  <= 10'd512;
            frame_h_reg  <= 10'd512;
        end else if (cfg_valid) begin
            case (prds_pkg::reg_idx_t'(cfg_index))
                prds_pkg::REG_FOCAL_X:      focal_x_reg  <= cfg_data;
                prds_pkg::REG_FOCAL_Y:      focal_y_reg  <= cfg_data;
                prds_pkg::REG_CENTER_X:     center_x_reg <= cfg_data[24:0];
                prds_pkg::REG_CENTER_Y:     center_y_reg <= cfg_data[24:0];
                prds_pkg::REG_FRAME_WIDTH:  frame_w_reg  <= cfg_data[9:0];
                prds_pkg::REG_FRAME_HEIGHT: frame_h_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic               kind_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] ru_reg, rv_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            px_reg   <= s_point_x;
            py_reg   <= s_point_y;
            pz_reg   <= s_point_z;
            ru_reg   <= s_ref_u;
            rv_reg   <= s_ref_v;
        end
    end

    logic neg_u, neg_v;
    assign neg_u = px_reg[31];
    assign neg_v = !py_reg[31] && (py_reg != 32'sd0);

    // multiply then restoring division, one quotient bit per cycle
    logic [31:0]   mag, focal;
    logic [PW-1:0] quo_reg, quo_step;
    logic [31:0]   rem_reg, rem_step;
    logic [32:0]   trial;
    logic [CW-1:0] cnt_reg;
    logic [QW-1:0] qsat, qu_reg, qv_reg;

    always_comb begin
        if (cmd.sel) begin
            mag   = py_reg[31] ? 32'(-py_reg) : 32'(py_reg);
            focal = focal_y_reg;
        end else begin
            mag   = px_reg[31] ? 32'(-px_reg) : 32'(px_reg);
            focal = focal_x_reg;
        end
    end

    always_comb begin
        trial    = {rem_reg, quo_reg[PW-1]};
        quo_step = {quo_reg[PW-2:0], 1'b0};
        rem_step = trial[31:0];
        if (trial >= {1'b0, pz_reg}) begin
            rem_step    = 32'(trial - {1'b0, pz_reg});
            quo_step[0] = 1'b1;
        end
        qsat = (quo_step > prds_pkg::QUOT_SAT) ? prds_pkg::QUOT_SAT[QW-1:0] : quo_step[QW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            quo_reg <= PW'(focal) * PW'(mag);
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.div_store) begin
            if (cmd.sel) qv_reg <= qsat;
            else         qu_reg <= qsat;
        end
    end

    // sign and principal point
    logic signed [UW-1:0] su, sv, u_reg, v_reg;

    always_comb begin
        su = $signed({{(UW-QW){1'b0}}, qu_reg});
        sv = $signed({{(UW-QW){1'b0}}, qv_reg});
        if (neg_u) su = -su;
        if (neg_v) sv = -sv;
    end

    always_ff @(posedge aclk) begin
        if (cmd.proj) begin
            u_reg <= su + $signed({{(UW-25){1'b0}}, center_x_reg});
            v_reg <= sv + $signed({{(UW-25){1'b0}}, center_y_reg});
        end
    end

    // rounding, frame test, reference error
    logic [UW-1:0] abs_u, abs_v, rnd_u, rnd_v;
    logic [RW-1:0] rx, ry, rx_reg, ry_reg;
    logic [RW-1:0] lim_w, lim_h;
    logic          vis;
    logic signed [UW:0] du, dv;
    logic [UW:0]   adu, adv;
    logic [31:0]   edu, edv, edu_reg, edv_reg;
    logic          vis_reg;

    always_comb begin
        abs_u = u_reg[UW-1] ? UW'(-u_reg) : UW'(u_reg);
        abs_v = v_reg[UW-1] ? UW'(-v_reg) : UW'(v_reg);
        rnd_u = abs_u + UW'(32'h8000);
        rnd_v = abs_v + UW'(32'h8000);
        rx    = rnd_u[UW-1:16];
        ry    = rnd_v[UW-1:16];
        lim_w = (RW'(frame_w_reg) > RW'(MAX_FRAME_WIDTH))  ? RW'(MAX_FRAME_WIDTH)
                                                            : RW'(frame_w_reg);
        lim_h = (RW'(frame_h_reg) > RW'(MAX_FRAME_HEIGHT)) ? RW'(MAX_FRAME_HEIGHT)
                                                            : RW'(frame_h_reg);
        // a negative u that rounds to zero still lands on column zero
        vis = (!u_reg[UW-1] || rx == '0) && (rx < lim_w) &&
              (!v_reg[UW-1] || ry == '0) && (ry < lim_h);
        du  = $signed({u_reg[UW-1], u_reg})
            - $signed({{(UW-31){ru_reg[15]}}, ru_reg, 16'd0});
        dv  = $signed({v_reg[UW-1], v_reg})
            - $signed({{(UW-31){rv_reg[15]}}, rv_reg, 16'd0});
        adu = du[UW] ? (UW+1)'(-du) : (UW+1)'(du);
        adv = dv[UW] ? (UW+1)'(-dv) : (UW+1)'(dv);
        edu = (adu[UW:32] != '0) ? 32'hFFFF_FFFF : adu[31:0];
        edv = (adv[UW:32] != '0) ? 32'hFFFF_FFFF : adv[31:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vis_reg <= 1'b0;
        end else if (cmd.fin) begin
            vis_reg <= vis;
            rx_reg  <= rx;
            ry_reg  <= ry;
            edu_reg <= edu;
            edv_reg <= edv;
        end
    end

    // depth store with clear sweep
    logic [ADDR_W-1:0] clr_reg, pix_addr, waddr;
    logic [31:0]       rdata, wdata;
    logic              nearer, we, wr_reg;

    assign pix_addr = ADDR_W'(ry_reg[YW-1:0]) * ADDR_W'(MAX_FRAME_WIDTH)
                    + ADDR_W'(rx_reg[XW-1:0]);
    assign nearer   = $unsigned(pz_reg) < rdata;
    assign we       = cmd.clr_step || (cmd.mem_test && nearer);
    assign waddr    = cmd.clr_step ? clr_reg : pix_addr;
    assign wdata    = cmd.clr_step ? 32'hFFFF_FFFF : 32'(pz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_init) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            wr_reg <= 1'b0;
        end else if (cmd.mem_test) begin
            wr_reg <= nearer;
        end
    end

    prds_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_depth_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (pix_addr),
        .rdata (rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_visible <= vis_reg;
            m_written <= vis_reg & wr_reg;
            m_pixel_x <= vis_reg ? rx_reg[8:0] : 9'd0;
            m_pixel_y <= vis_reg ? ry_reg[8:0] : 9'd0;
            m_abs_du  <= vis_reg ? edu_reg : 32'd0;
            m_abs_dv  <= vis_reg ? edv_reg : 32'd0;
        end
    end

    assign st.kind     = kind_reg;
    assign st.z_pos    = !pz_reg[31] && (pz_reg != 32'sd0);
    assign st.div_last = (cnt_reg == CW'(PW - 1));
    assign st.clr_last = (clr_reg == ADDR_W'(DEPTH - 1));
    assign st.visible  = vis_reg;

endmodule

@@ rtl/point_reprojection_depth_splat_unit.sv @@
// ----------------------------------------------------------------------------
// point_reprojection_depth_splat_unit
// Pinhole projection of Q16.16 points with a per-pixel depth-tested store.
// ----------------------------------------------------------------------------
// One item is worked at a time. A point item runs from transfer to result
// through a 32x32 multiply and a 64-step restoring divide by Z for each of
// u and v on one shared divider, then rounding, a depth store read and a
// conditional write. A point with Z <= 0 skips these steps and returns a
// result with m_visible low. A clear item and reset each sweep all
// MAX_FRAME_WIDTH*MAX_FRAME_HEIGHT entries of the depth store, one entry a
// cycle, with s_ready low; config writes are taken at any time.
module point_reprojection_depth_splat_unit #(
    parameter int unsigned MAX_FRAME_WIDTH  = 512,
    parameter int unsigned MAX_FRAME_HEIGHT = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic signed [15:0] s_ref_u,
    input  logic signed [15:0] s_ref_v,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [8:0]         m_pixel_x,
    output logic [8:0]         m_pixel_y,
    output logic               m_visible,
    output logic               m_written,
    output logic [31:0]        m_abs_du,
    output logic [31:0]        m_abs_dv
);

    prds_pkg::cmd_t    cmd;
    prds_pkg::status_t st;

    assign cfg_ready = 1'b1;

    prds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    prds_dpath #(
        .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_kind    (s_kind),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .s_point_z (s_point_z),
        .s_ref_u   (s_ref_u),
        .s_ref_v   (s_ref_v),
        .cmd       (cmd),
        .st        (st),
        .m_pixel_x (m_pixel_x),
        .m_pixel_y (m_pixel_y),
        .m_visible (m_visible),
        .m_written (m_written),
        .m_abs_du  (m_abs_du),
        .m_abs_dv  (m_abs_dv)
    );

endmodule
